[hdl/source_tokenizer_defines.svh]
// ----------------------------------------------------------------------------
// source_tokenizer_defines.svh
// assertion macros for the source tokenizer, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef SOURCE_TOKENIZER_DEFINES_SVH
`define SOURCE_TOKENIZER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clk_i, off during reset
`define STOK_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("stok assertion failed");
// next-cycle implication, sampled on clk_i, off during reset
`define STOK_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("stok assertion failed");
`else
`define STOK_ASSERT_NOW(label, ante, cons)
`define STOK_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[hdl/stok_pkg.sv]
// ----------------------------------------------------------------------------
// stok_pkg
// types, codes and keyword constants shared by the source tokenizer
// ----------------------------------------------------------------------------
package stok_pkg;

  localparam int CHAR_W         = 8;
  localparam int FIELD_W        = 16;
  localparam int TYPE_W         = 5;
  localparam int POS_BITS_DEF   = 16;
  localparam int KW_CHARS_DEF   = 5;
  localparam int KW_COUNT       = 8;
  localparam int MAX_TOKENS     = 3;
  localparam int CNT_W          = 2;

  localparam logic [FIELD_W-1:0] FIRST_LINE_RESET = 16'd1;

  typedef enum logic [TYPE_W-1:0] {
    TT_LPAREN   = 5'd0,
    TT_RPAREN   = 5'd1,
    TT_LBRACE   = 5'd2,
    TT_RBRACE   = 5'd3,
    TT_PLUS     = 5'd4,
    TT_MINUS    = 5'd5,
    TT_STAR     = 5'd6,
    TT_SLASH    = 5'd7,
    TT_SEMI     = 5'd8,
    TT_ASSIGN   = 5'd9,
    TT_EQEQ     = 5'd10,
    TT_LESS     = 5'd11,
    TT_NUMBER   = 5'd12,
    TT_IDENT    = 5'd13,
    TT_KW_LET   = 5'd14,
    TT_KW_IF    = 5'd15,
    TT_KW_ELSE  = 5'd16,
    TT_KW_WHILE = 5'd17,
    TT_KW_PRINT = 5'd18,
    TT_KW_INPUT = 5'd19,
    TT_KW_TRUE  = 5'd20,
    TT_KW_FALSE = 5'd21,
    TT_END      = 5'd22,
    TT_ERROR    = 5'd23
  } tok_type_e;

  typedef enum logic [1:0] {
    PK_NONE  = 2'd0,
    PK_NUM   = 2'd1,
    PK_IDENT = 2'd2,
    PK_EQ    = 2'd3
  } pend_kind_e;

  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7b;
  localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7d;
  localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2b;
  localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2a;
  localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2f;
  localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3b;
  localparam logic [CHAR_W-1:0] CH_LESS   = 8'h3c;
  localparam logic [CHAR_W-1:0] CH_EQUAL  = 8'h3d;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0d;
  localparam logic [CHAR_W-1:0] CH_LF     = 8'h0a;

  // keyword text, first character in the low byte
  localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
    64'h0000_0000_0074_656c,  // let
    64'h0000_0000_0000_6669,  // if
    64'h0000_0000_6573_6c65,  // else
    64'h0000_0065_6c69_6877,  // while
    64'h0000_0074_6e69_7270,  // print
    64'h0000_0074_7570_6e69,  // input
    64'h0000_0000_6575_7274,  // true
    64'h0000_0065_736c_6166   // false
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd3, 4'd2, 4'd4, 4'd5, 4'd5, 4'd5, 4'd4, 4'd5
  };

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              char_valid;
    logic              end_of_source;
  } item_t;

  typedef struct packed {
    tok_type_e          ttype;
    logic [FIELD_W-1:0] start;
    logic [FIELD_W-1:0] length;
    logic [FIELD_W-1:0] line;
    logic [CHAR_W-1:0]  bad;
  } token_t;

  // tokens caused by one item, slot 0 goes out first
  typedef struct packed {
    token_t [MAX_TOKENS-1:0] slot;
    logic [CNT_W-1:0]        count;
  } tok_bundle_t;

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [CHAR_W-1:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a)) ||
           (c == 8'h5f);
  endfunction

  function automatic token_t make_tok(input tok_type_e t, input logic [FIELD_W-1:0] s,
                                      input logic [FIELD_W-1:0] l,
                                      input logic [FIELD_W-1:0] ln,
                                      input logic [CHAR_W-1:0] b);
    token_t r;
    r.ttype  = t;
    r.start  = s;
    r.length = l;
    r.line   = ln;
    r.bad    = b;
    return r;
  endfunction

endpackage

[hdl/stok_ifs.sv]
// ----------------------------------------------------------------------------
// stok_ifs
// valid/ready channels for source bytes and for tokens
// ----------------------------------------------------------------------------
interface stok_src_if import stok_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              char_valid;
  logic              end_of_source;

  modport source (output valid, char_code, char_valid, end_of_source, input ready);
  modport sink   (input valid, char_code, char_valid, end_of_source, output ready);
endinterface

interface stok_tok_if import stok_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TYPE_W-1:0]  token_type;
  logic [FIELD_W-1:0] token_start;
  logic [FIELD_W-1:0] token_length;
  logic [FIELD_W-1:0] line_number;
  logic [CHAR_W-1:0]  bad_char;
  logic               last_of_run;

  modport source (output valid, token_type, token_start, token_length, line_number,
                  bad_char, last_of_run, input ready);
  modport sink   (input valid, token_type, token_start, token_length, line_number,
                  bad_char, last_of_run, output ready);
endinterface

[hdl/stok_scan.sv]
// ----------------------------------------------------------------------------
// stok_scan
// lexer state and the tokens one byte causes, state updated on accept
// ----------------------------------------------------------------------------
module stok_scan import stok_pkg::*; #(
  parameter int POS_BITS      = POS_BITS_DEF,
  parameter int KEYWORD_CHARS = KW_CHARS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  item_t              item_i,
  input  logic               cfg_we_i,
  input  logic [FIELD_W-1:0] cfg_wdata_i,
  output tok_bundle_t        bundle_o
);

  localparam int PREFIX_W = 8 * KEYWORD_CHARS;

  pend_kind_e           kind_q, kind_d;
  logic [POS_BITS-1:0]  pstart_q, pstart_d;
  logic [POS_BITS-1:0]  plen_q, plen_d;
  logic [POS_BITS-1:0]  bpos_q, bpos_d;
  logic [FIELD_W-1:0]   line_q, line_d;
  logic [FIELD_W-1:0]   first_line_q;
  logic [PREFIX_W-1:0]  prefix_q, prefix_d;

  function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic logic [FIELD_W-1:0] to_field(input logic [POS_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[FIELD_W-1:0];
  endfunction

  function automatic logic [PREFIX_W-1:0] add_byte(input logic [PREFIX_W-1:0] p,
                                                   input logic [POS_BITS-1:0] len,
                                                   input logic [CHAR_W-1:0] c);
    logic [PREFIX_W-1:0] r;
    r = p;
    for (int i = 0; i < KEYWORD_CHARS; i++) begin
      if (len == POS_BITS'(i)) r[8*i +: 8] = c;
    end
    return r;
  endfunction

  function automatic tok_type_e word_type(input logic [POS_BITS-1:0] len,
                                          input logic [PREFIX_W-1:0] p);
    tok_type_e t;
    t = TT_IDENT;
    for (int k = 0; k < KW_COUNT; k++) begin
      if ((len == POS_BITS'(KW_LEN[k])) && (p == KW_TEXT[k][PREFIX_W-1:0])) begin
        t = tok_type_e'(5'(TT_KW_LET) + 5'(k));
      end
    end
    return t;
  endfunction

  // token for whatever is pending, meaningless when nothing is
  function automatic token_t pend_tok(input pend_kind_e k, input logic [POS_BITS-1:0] s,
                                      input logic [POS_BITS-1:0] l,
                                      input logic [PREFIX_W-1:0] p,
                                      input logic [FIELD_W-1:0] ln);
    token_t t;
    case (k)
      PK_NUM:   t = make_tok(TT_NUMBER, to_field(s), to_field(l), ln, '0);
      PK_IDENT: t = make_tok(word_type(l, p), to_field(s), to_field(l), ln, '0);
      PK_EQ:    t = make_tok(TT_ASSIGN, to_field(s), FIELD_W'(1), ln, '0);
      default:  t = make_tok(TT_ERROR, '0, '0, ln, '0);
    endcase
    return t;
  endfunction

  logic [CHAR_W-1:0]       c;
  token_t [MAX_TOKENS-1:0] slot;
  logic [CNT_W-1:0]        n;
  tok_type_e               single_t;
  logic                    single_hit;

  assign c = item_i.char_code;

  always_comb begin
    kind_d     = kind_q;
    pstart_d   = pstart_q;
    plen_d     = plen_q;
    bpos_d     = bpos_q;
    line_d     = line_q;
    prefix_d   = prefix_q;
    slot       = '0;
    n          = '0;
    single_t   = TT_ERROR;
    single_hit = 1'b0;

    if (item_i.char_valid) begin
      if ((kind_q == PK_NUM) && is_digit(c)) begin
        plen_d = sat_inc(plen_q);
      end else if ((kind_q == PK_IDENT) && (is_alpha(c) || is_digit(c))) begin
        prefix_d = add_byte(prefix_q, plen_q, c);
        plen_d   = sat_inc(plen_q);
      end else if ((kind_q == PK_EQ) && (c == CH_EQUAL)) begin
        slot[n] = make_tok(TT_EQEQ, to_field(pstart_q), FIELD_W'(2), line_d, '0);
        n       = n + 1'b1;
        kind_d  = PK_NONE;
        plen_d  = '0;
      end else begin
        // flush the pending token, then look at the byte itself
        if (kind_q != PK_NONE) begin
          slot[n] = pend_tok(kind_q, pstart_q, plen_q, prefix_q, line_d);
          n       = n + 1'b1;
        end
        kind_d   = PK_NONE;
        plen_d   = '0;
        prefix_d = '0;
        case (c)
          CH_LPAREN: begin single_t = TT_LPAREN; single_hit = 1'b1; end
          CH_RPAREN: begin single_t = TT_RPAREN; single_hit = 1'b1; end
          CH_LBRACE: begin single_t = TT_LBRACE; single_hit = 1'b1; end
          CH_RBRACE: begin single_t = TT_RBRACE; single_hit = 1'b1; end
          CH_PLUS:   begin single_t = TT_PLUS;   single_hit = 1'b1; end
          CH_MINUS:  begin single_t = TT_MINUS;  single_hit = 1'b1; end
          CH_STAR:   begin single_t = TT_STAR;   single_hit = 1'b1; end
          CH_SLASH:  begin single_t = TT_SLASH;  single_hit = 1'b1; end
          CH_SEMI:   begin single_t = TT_SEMI;   single_hit = 1'b1; end
          CH_LESS:   begin single_t = TT_LESS;   single_hit = 1'b1; end
          CH_EQUAL: begin
            kind_d   = PK_EQ;
            pstart_d = bpos_q;
            plen_d   = POS_BITS'(1);
          end
          CH_SPACE, CH_TAB, CH_CR: begin
          end
          CH_LF: begin
            line_d = (line_q == '1) ? line_q : line_q + 1'b1;
          end
          default: begin
            if (is_digit(c)) begin
              kind_d   = PK_NUM;
              pstart_d = bpos_q;
              plen_d   = POS_BITS'(1);
            end else if (is_alpha(c)) begin
              kind_d   = PK_IDENT;
              pstart_d = bpos_q;
              prefix_d = add_byte('0, '0, c);
              plen_d   = POS_BITS'(1);
            end else begin
              slot[n] = make_tok(TT_ERROR, to_field(bpos_q), FIELD_W'(1), line_d, c);
              n       = n + 1'b1;
            end
          end
        endcase
        if (single_hit) begin
          slot[n] = make_tok(single_t, to_field(bpos_q), FIELD_W'(1), line_d, '0);
          n       = n + 1'b1;
        end
      end
      bpos_d = sat_inc(bpos_q);
    end

    if (item_i.end_of_source) begin
      if (kind_d != PK_NONE) begin
        slot[n] = pend_tok(kind_d, pstart_d, plen_d, prefix_d, line_d);
        n       = n + 1'b1;
      end
      slot[n]  = make_tok(TT_END, to_field(bpos_d), '0, line_d, '0);
      n        = n + 1'b1;
      kind_d   = PK_NONE;
      pstart_d = '0;
      plen_d   = '0;
      bpos_d   = '0;
      prefix_d = '0;
      line_d   = first_line_q;
    end
  end

  assign bundle_o.slot  = slot;
  assign bundle_o.count = n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q       <= PK_NONE;
      pstart_q     <= '0;
      plen_q       <= '0;
      bpos_q       <= '0;
      line_q       <= FIRST_LINE_RESET;
      first_line_q <= FIRST_LINE_RESET;
      prefix_q     <= '0;
    end else begin
      if (accept_i) begin
        kind_q   <= kind_d;
        pstart_q <= pstart_d;
        plen_q   <= plen_d;
        bpos_q   <= bpos_d;
        prefix_q <= prefix_d;
      end
      // a register write also reloads the line counter
      if (cfg_we_i) begin
        first_line_q <= cfg_wdata_i;
        line_q       <= cfg_wdata_i;
      end else if (accept_i) begin
        line_q <= line_d;
      end
    end
  end

endmodule

[hdl/stok_outq.sv]
// ----------------------------------------------------------------------------
// stok_outq
// result register for the tokens of one item, drained one per cycle on pop_i
// ----------------------------------------------------------------------------
module stok_outq import stok_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  tok_bundle_t             bundle_i,
  input  logic                    pop_i,
  output logic                    can_load_o,
  output logic                    valid_o,
  output logic                    last_o,
  output token_t                  head_o
);

  token_t [MAX_TOKENS-1:0] slot_q, slot_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;

  // a new item may load when the register is empty or its last token leaves now
  assign can_load_o = (cnt_q == '0) || ((cnt_q == CNT_W'(1)) && pop_i);
  assign valid_o    = (cnt_q != '0);
  assign last_o     = (cnt_q == CNT_W'(1));
  assign head_o     = slot_q[0];

  always_comb begin
    slot_d = slot_q;
    cnt_d  = cnt_q;
    if (accept_i) begin
      slot_d = bundle_i.slot;
      cnt_d  = bundle_i.count;
    end else if (pop_i && valid_o) begin
      for (int i = 0; i < MAX_TOKENS - 1; i++) slot_d[i] = slot_q[i+1];
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

[hdl/source_tokenizer.sv]
// ----------------------------------------------------------------------------
// source_tokenizer
// streaming lexer: source bytes in, typed tokens with position and line out
// ----------------------------------------------------------------------------
//
//   channel   dir  handshake          carries
//   src_i     in   valid / ready      char_code, char_valid, end_of_source
//   tok_o     out  valid / ready      token_type, start, length, line, bad_char,
//                                     last_of_run
//   cfg       in   cfg_we_i           first_line (cfg_wdata_i)
//
// an item is classified in the cycle it is accepted; its tokens (up to three) are
// stored in the result register at that edge and show on tok_o the cycle after
// the result register drains one token per cycle while tok_o.ready is high, so an
// item causing more than one token holds off the next item until its last token is
// being taken; items with zero or one token go at one per cycle while tok_o is ready
// src_i.ready stays high while the last waiting token is being taken, so a stall
// on tok_o stalls src_i whenever the result register holds a token
// reset clears the lexer state and the result register, first_line returns to 1
// ----------------------------------------------------------------------------
`include "source_tokenizer_defines.svh"

module source_tokenizer import stok_pkg::*; #(
  parameter int POS_BITS      = POS_BITS_DEF,
  parameter int KEYWORD_CHARS = KW_CHARS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  stok_src_if.sink           src_i,
  stok_tok_if.source         tok_o,
  input  logic               cfg_we_i,
  input  logic [FIELD_W-1:0] cfg_wdata_i
);

  item_t       item;
  tok_bundle_t bundle;
  token_t      head;
  logic        in_acc;
  logic        can_load;
  logic        out_valid;
  logic        out_last;

  assign item.char_code     = src_i.char_code;
  assign item.char_valid    = src_i.char_valid;
  assign item.end_of_source = src_i.end_of_source;

  assign src_i.ready = can_load;
  assign in_acc      = src_i.valid && can_load;

  // lexer state plus the combinational token builder
  stok_scan #(
    .POS_BITS      (POS_BITS),
    .KEYWORD_CHARS (KEYWORD_CHARS)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_acc),
    .item_i      (item),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .bundle_o    (bundle)
  );

  // result register, tokens leave in order
  stok_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (in_acc),
    .bundle_i   (bundle),
    .pop_i      (tok_o.ready),
    .can_load_o (can_load),
    .valid_o    (out_valid),
    .last_o     (out_last),
    .head_o     (head)
  );

  assign tok_o.valid        = out_valid;
  assign tok_o.token_type   = head.ttype;
  assign tok_o.token_start  = head.start;
  assign tok_o.token_length = head.length;
  assign tok_o.line_number  = head.line;
  assign tok_o.bad_char     = head.bad;
  assign tok_o.last_of_run  = out_last;

  // an end item always leaves at least the end token behind
  `STOK_ASSERT_NEXT(a_end_gives_token, in_acc && src_i.end_of_source, tok_o.valid)
  // an empty item leaves the result register empty
  `STOK_ASSERT_NEXT(a_empty_no_token,
                    in_acc && !src_i.char_valid && !src_i.end_of_source, !tok_o.valid)
  // loading over a waiting token only when that token is the last one and leaves now
  `STOK_ASSERT_NOW(a_no_overwrite, in_acc && tok_o.valid,
                   tok_o.ready && tok_o.last_of_run)

endmodule
